// File: src/smp_pkg.sv
// Shared constants, codes and packet byte formatting for the serial mouse packetizer.
`default_nettype none

package smp_pkg;

	localparam int RING_DEPTH_DEF = 256;
	localparam int POS_BITS_DEF   = 12;

	// Item operation codes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_LINES = 1'b1;

	// Protocol select codes
	localparam logic PROTO_THREE = 1'b0;
	localparam logic PROTO_FIVE  = 1'b1;

	// Identification bytes sent after a CTS rise in three-byte mode
	localparam logic [7:0] ID_BYTE0 = 8'h4D;
	localparam logic [7:0] ID_BYTE1 = 8'h33;

	// Byte positions inside a packet
	localparam logic [2:0] PKT_B0 = 3'd0;
	localparam logic [2:0] PKT_B1 = 3'd1;
	localparam logic [2:0] PKT_B2 = 3'd2;
	localparam logic [2:0] PKT_B3 = 3'd3;
	localparam logic [2:0] PKT_B4 = 3'd4;

	// Packet lengths in bytes
	localparam logic [2:0] LEN_THREE     = 3'd3;
	localparam logic [2:0] LEN_THREE_MID = 3'd4;
	localparam logic [2:0] LEN_FIVE      = 3'd5;

	// Form one byte of a packet from the clamped step and the sampled buttons.
	function automatic logic [7:0] pkt_byte(
		input logic       proto,
		input logic [2:0] idx,
		input logic [2:0] nb,
		input logic [7:0] sx,
		input logic [7:0] sy
	);
		logic [7:0] b;
		b = 8'h00;
		if (proto == PROTO_THREE) begin
			case (idx)
				PKT_B0:  b = {2'b01, nb[1], nb[0], sy[7:6], sx[7:6]};
				PKT_B1:  b = {2'b00, sx[5:0]};
				PKT_B2:  b = {2'b00, sy[5:0]};
				PKT_B3:  b = {2'b00, nb[2], 5'b00000};
				default: b = 8'h00;
			endcase
		end else begin
			case (idx)
				PKT_B0:  b = {5'b10000, ~nb[1], ~nb[2], ~nb[0]};
				PKT_B1:  b = sx;
				PKT_B2:  b = sy;
				default: b = 8'h00;
			endcase
		end
		return b;
	endfunction

endpackage

`default_nettype wire

// File: src/smp_ring.sv
// Byte ring storage: one write port, one read port with registered read data.
`default_nettype none

module smp_ring #(
	parameter int RING_DEPTH = 256
) (
	input  wire logic                          clk,
	input  wire logic                          wr_en,
	input  wire logic [$clog2(RING_DEPTH)-1:0] wr_addr,
	input  wire logic [7:0]                    wr_data,
	input  wire logic                          rd_en,
	input  wire logic [$clog2(RING_DEPTH)-1:0] rd_addr,
	output logic      [7:0]                    rd_data
);
	import smp_pkg::*;

	logic [7:0] mem [RING_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: src/serial_mouse_packetizer_core.sv
// Serial mouse packetizer: handshake line mapping, delta packetizing into a byte ring.
// Handshake item: to ST_RESULT, via ST_ID0 and ST_ID1 when identification bytes are queued.
// Scan tick: to ST_RESULT when not scanning, via ST_READ when nothing is left to send, otherwise
// via ST_GEN if a fresh sample has packet bytes to write into the ring (up to 85 bytes at 12-bit
// positions), then ST_READ and ST_WAIT; the single ring write port writes one byte per cycle.
// One item in flight at a time; the next item is taken once the result is in the output register.
// Reset (arst_n low, asynchronous) clears control state: DSR and CTS high, not scanning,
// ring empty.
`default_nettype none

module serial_mouse_packetizer_core #(
	parameter int RING_DEPTH = smp_pkg::RING_DEPTH_DEF,
	parameter int POS_BITS   = smp_pkg::POS_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// request channel
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                op,
	input  wire logic [POS_BITS-1:0] pos_x,
	input  wire logic [POS_BITS-1:0] pos_y,
	input  wire logic [2:0]          buttons,
	input  wire logic                dtr,
	input  wire logic                rts,
	// result channel
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     byte_valid,
	output logic [7:0]               byte_out,
	output logic                     dsr_out,
	output logic                     cts_out,
	// configuration channel
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic                cfg_data
);
	import smp_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);
	// deltas need one bit above the position width: a negated minimum delta must fit
	localparam int DW = POS_BITS + 1;

	localparam logic [AW-1:0]        LAST_ADDR = AW'(RING_DEPTH - 1);
	localparam logic signed [DW-1:0] CLAMP_LO  = DW'(-128);
	localparam logic signed [DW-1:0] CLAMP_HI  = DW'(127);

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ID0    = 3'd1;
	localparam logic [2:0] ST_ID1    = 3'd2;
	localparam logic [2:0] ST_GEN    = 3'd3;
	localparam logic [2:0] ST_READ   = 3'd4;
	localparam logic [2:0] ST_WAIT   = 3'd5;
	localparam logic [2:0] ST_RESULT = 3'd6;

	function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
		return (a == LAST_ADDR) ? '0 : a + AW'(1);
	endfunction

	// control state
	logic [2:0]          state_q;
	logic [AW-1:0]       head_q;
	logic [AW-1:0]       tail_q;
	logic [POS_BITS-1:0] last_x_q;
	logic [POS_BITS-1:0] last_y_q;
	logic [2:0]          last_buttons_q;
	logic [1:0]          line_status_q;   // bit0 DSR, bit1 CTS
	logic                scanning_q;
	logic                proto_q;
	logic                res_vld_q;
	logic [2:0]          idx_q;

	// working payload of the current sample
	logic signed [DW-1:0] dx_q;
	logic signed [DW-1:0] dy_q;
	logic [2:0]           nb_q;
	logic                 chg_mid_q;

	// output register
	logic       out_valid_q;
	logic       byte_valid_q;
	logic [7:0] byte_out_q;
	logic       dsr_q;
	logic       cts_q;

	logic in_acc;
	logic out_free;
	logic ring_empty;

	logic [POS_BITS-1:0]  diff_x;
	logic [POS_BITS-1:0]  diff_y;
	logic signed [DW-1:0] dx_smp;
	logic signed [DW-1:0] dy_smp;
	logic [2:0]           changed;
	logic                 no_motion;

	logic [7:0]           sx;
	logic [7:0]           sy;
	logic signed [DW-1:0] dx_nx;
	logic signed [DW-1:0] dy_nx;
	logic [2:0]           pkt_len;
	logic                 pkt_last;

	logic          wr_en;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [7:0]    rd_data;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign ring_empty = (head_q == tail_q);
	assign cfg_ready = 1'b1;

	// Sample deltas: wrap at the position width, then sign-extend one bit.
	assign diff_x    = pos_x - last_x_q;
	assign diff_y    = pos_y - last_y_q;
	assign dx_smp    = {diff_x[POS_BITS-1], diff_x};
	assign dy_smp    = {diff_y[POS_BITS-1], diff_y};
	assign changed   = buttons ^ last_buttons_q;
	assign no_motion = (diff_x == '0) && (diff_y == '0) && (changed == 3'b000);

	// Clamp the remaining delta to one packet step of -128..127 per axis.
	always_comb begin
		if (dx_q < CLAMP_LO) begin
			sx = 8'h80;
		end else if (dx_q > CLAMP_HI) begin
			sx = 8'h7F;
		end else begin
			sx = dx_q[7:0];
		end
		if (dy_q < CLAMP_LO) begin
			sy = 8'h80;
		end else if (dy_q > CLAMP_HI) begin
			sy = 8'h7F;
		end else begin
			sy = dy_q[7:0];
		end
	end

	assign dx_nx = dx_q - {{(DW-8){sx[7]}}, sx};
	assign dy_nx = dy_q - {{(DW-8){sy[7]}}, sy};

	// three-byte packets grow a fourth byte while the middle button changed
	assign pkt_len  = (proto_q == PROTO_FIVE) ? LEN_FIVE :
	                  (chg_mid_q ? LEN_THREE_MID : LEN_THREE);
	assign pkt_last = (idx_q == pkt_len - 3'd1);

	// Ring write port: identification bytes or packet bytes, always at the head.
	always_comb begin
		wr_en   = 1'b0;
		wr_data = 8'h00;
		case (state_q)
			ST_ID0: begin
				wr_en   = 1'b1;
				wr_data = ID_BYTE0;
			end
			ST_ID1: begin
				wr_en   = 1'b1;
				wr_data = ID_BYTE1;
			end
			ST_GEN: begin
				wr_en   = 1'b1;
				wr_data = pkt_byte(proto_q, idx_q, nb_q, sx, sy);
			end
			default: begin
				wr_en   = 1'b0;
				wr_data = 8'h00;
			end
		endcase
	end

	// Read the oldest byte once all writes for this tick have landed.
	assign rd_en = (state_q == ST_READ) && !ring_empty;

	smp_ring #(
		.RING_DEPTH(RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (head_q),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (tail_q),
		.rd_data (rd_data)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proto_q <= PROTO_THREE;
		end else if (cfg_valid && cfg_ready) begin
			proto_q <= cfg_data;
		end
	end

	// Sample payload: no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			dx_q      <= dx_smp;
			dy_q      <= (proto_q == PROTO_FIVE) ? -dy_smp : dy_smp;
			nb_q      <= buttons;
			chg_mid_q <= changed[2];
		end else if (state_q == ST_GEN && pkt_last) begin
			dx_q <= dx_nx;
			dy_q <= dy_nx;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			head_q         <= '0;
			tail_q         <= '0;
			last_x_q       <= '0;
			last_y_q       <= '0;
			last_buttons_q <= '0;
			line_status_q  <= 2'b11;
			scanning_q     <= 1'b0;
			res_vld_q      <= 1'b0;
			idx_q          <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (op == OP_LINES) begin
							// map DTR to DSR and RTS to CTS
							line_status_q <= {rts, dtr};
							res_vld_q     <= 1'b0;
							state_q       <= ST_RESULT;
							if (rts != line_status_q[1]) begin
								// any CTS edge empties the ring
								head_q <= '0;
								tail_q <= '0;
								if (rts) begin
									last_buttons_q <= '0;
									scanning_q     <= 1'b1;
									if (proto_q == PROTO_THREE) begin
										state_q <= ST_ID0;
									end
								end else begin
									scanning_q <= 1'b0;
								end
							end
						end else if (!scanning_q) begin
							// drop ticks while not scanning
							res_vld_q <= 1'b0;
							state_q   <= ST_RESULT;
						end else if (ring_empty) begin
							// take a fresh sample only when the ring has drained
							last_x_q       <= pos_x;
							last_y_q       <= pos_y;
							last_buttons_q <= buttons;
							idx_q          <= '0;
							state_q        <= no_motion ? ST_READ : ST_GEN;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_ID0: begin
					head_q  <= next_addr(head_q);
					state_q <= ST_ID1;
				end
				ST_ID1: begin
					head_q    <= next_addr(head_q);
					res_vld_q <= 1'b0;
					state_q   <= ST_RESULT;
				end
				ST_GEN: begin
					// one packet byte per cycle; the head wraps and may overrun the tail
					head_q <= next_addr(head_q);
					if (pkt_last) begin
						idx_q <= '0;
						if (dx_nx == '0 && dy_nx == '0) begin
							state_q <= ST_READ;
						end
					end else begin
						idx_q <= idx_q + 3'd1;
					end
				end
				ST_READ: begin
					if (!ring_empty) begin
						tail_q    <= next_addr(tail_q);
						res_vld_q <= 1'b1;
						state_q   <= ST_WAIT;
					end else begin
						res_vld_q <= 1'b0;
						state_q   <= ST_RESULT;
					end
				end
				ST_WAIT: begin
					// read data arrives this cycle
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: loads the finished result, frees on a taken request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && out_free) begin
			byte_valid_q <= res_vld_q;
			byte_out_q   <= res_vld_q ? rd_data : 8'h00;
			dsr_q        <= line_status_q[0];
			cts_q        <= line_status_q[1];
		end
	end

	assign out_valid  = out_valid_q;
	assign byte_valid = byte_valid_q;
	assign byte_out   = byte_out_q;
	assign dsr_out    = dsr_q;
	assign cts_out    = cts_q;

	// Checks on the sequencer
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != ST_IDLE)
		else $error("item accepted but sequencer did not leave idle");

	a_wait_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAIT |-> $past(state_q) == ST_READ)
		else $error("read wait state entered without a ring read");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GEN |-> idx_q < pkt_len)
		else $error("packet byte index beyond packet length");

	a_empty_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> byte_out == 8'h00)
		else $error("byte field not zero on a result without a byte");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the serial mouse packetizer core.
`timescale 1ns / 100ps

module tb_top;

	import smp_pkg::*;

	// One reply of the block: the byte sent, if any, and the line levels after the request.
	typedef struct packed {
		logic       byte_valid;
		logic [7:0] byte_out;
		logic       dsr;
		logic       cts;
	} reply_t;

	// Mirror of the mouse: line state, scan state, byte ring and last sample.
	// Every accepted request turns into exactly one expected reply.
	class mouse_stream_checker;
		logic [7:0]  ring [RING_DEPTH_DEF];
		logic [7:0]  head;
		logic [7:0]  tail;
		logic [11:0] last_x;
		logic [11:0] last_y;
		logic [2:0]  last_btn;
		logic        dsr;
		logic        cts;
		logic        scanning;
		logic        proto;
		reply_t      pending_replies[$];
		int          mismatches;

		function new();
			head       = 8'd0;
			tail       = 8'd0;
			last_x     = 12'd0;
			last_y     = 12'd0;
			last_btn   = 3'd0;
			dsr        = 1'b1;
			cts        = 1'b1;
			scanning   = 1'b0;
			proto      = PROTO_THREE;
			mismatches = 0;
		endfunction

		function void push_byte(logic [7:0] v);
			ring[head] = v;
			head       = head + 8'd1;
		endfunction

		// Position change, wrapped to 12 bits and read as signed.
		function int step_delta(logic [11:0] now_v, logic [11:0] was_v);
			logic [11:0] d;
			d = now_v - was_v;
			return int'($signed(d));
		endfunction

		function int clamp_step(int v);
			if (v < -128)
				return -128;
			if (v > 127)
				return 127;
			return v;
		endfunction

		// Take a sample and queue the packets that carry its motion.
		function void queue_motion(logic [11:0] nx, logic [11:0] ny, logic [2:0] nb);
			int         dx;
			int         dy;
			int         sx;
			int         sy;
			logic [2:0] changed;
			logic [7:0] ux;
			logic [7:0] uy;
			logic [7:0] lead;
			dx       = step_delta(nx, last_x);
			dy       = step_delta(ny, last_y);
			changed  = nb ^ last_btn;
			last_x   = nx;
			last_y   = ny;
			last_btn = nb;
			if (dx == 0 && dy == 0 && changed == 3'b000)
				return;
			if (proto == PROTO_THREE) begin
				do begin
					sx = clamp_step(dx);
					sy = clamp_step(dy);
					ux = 8'(sx);
					uy = 8'(sy);
					push_byte({2'b01, nb[1:0], uy[7:6], ux[7:6]});
					push_byte({2'b00, ux[5:0]});
					push_byte({2'b00, uy[5:0]});
					if (changed[2])
						push_byte({2'b00, nb[2], 5'b00000});
					dx -= sx;
					dy -= sy;
				end while (dx != 0 || dy != 0);
			end else begin
				lead = {5'b10000, ~nb[1], ~nb[2], ~nb[0]};
				dy   = -dy;
				do begin
					sx = clamp_step(dx);
					sy = clamp_step(dy);
					push_byte(lead);
					push_byte(8'(sx));
					push_byte(8'(sy));
					push_byte(8'h00);
					push_byte(8'h00);
					dx -= sx;
					dy -= sy;
				end while (dx != 0 || dy != 0);
			end
		endfunction

		function void note_request(logic o, logic [11:0] x, logic [11:0] y, logic [2:0] b,
				logic d, logic r);
			reply_t want;
			want = '0;
			if (o == OP_LINES) begin
				if (r != cts) begin
					head = 8'd0;
					tail = 8'd0;
					if (r) begin
						last_btn = 3'd0;
						if (proto == PROTO_THREE) begin
							push_byte(ID_BYTE0);
							push_byte(ID_BYTE1);
						end
						scanning = 1'b1;
					end else begin
						scanning = 1'b0;
					end
				end
				dsr = d;
				cts = r;
			end else if (scanning) begin
				if (head == tail)
					queue_motion(x, y, b);
				if (tail != head) begin
					want.byte_valid = 1'b1;
					want.byte_out   = ring[tail];
					tail            = tail + 8'd1;
				end
			end
			want.dsr = dsr;
			want.cts = cts;
			pending_replies.push_back(want);
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected reply: valid %0b byte %02h dsr %0b cts %0b",
						got.byte_valid, got.byte_out, got.dsr, got.cts);
				return;
			end
			want = pending_replies.pop_front();
			if (got.byte_valid !== want.byte_valid || got.byte_out !== want.byte_out ||
					got.dsr !== want.dsr || got.cts !== want.cts) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch exp/act: valid %0b/%0b byte %02h/%02h dsr %0b/%0b cts %0b/%0b",
						want.byte_valid, got.byte_valid, want.byte_out, got.byte_out,
						want.dsr, got.dsr, want.cts, got.cts);
			end
		endfunction

		function int queued_bytes();
			logic [7:0] n;
			n = head - tail;
			return int'(n);
		endfunction

		function int pending();
			return pending_replies.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [11:0] pos_x;
	logic [11:0] pos_y;
	logic [2:0]  buttons;
	logic        dtr;
	logic        rts;
	logic        out_valid;
	logic        out_stall;
	logic        byte_valid;
	logic [7:0]  byte_out;
	logic        dsr_out;
	logic        cts_out;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;

	mouse_stream_checker board;

	// Nominal mouse position and buttons that the random ticks walk from.
	logic [11:0] cur_x;
	logic [11:0] cur_y;
	logic [2:0]  cur_btn;

	// While a burst flag is set, that side runs without idle cycles.
	bit send_burst;
	bit recv_burst;

	serial_mouse_packetizer_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.buttons    (buttons),
		.dtr        (dtr),
		.rts        (rts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.byte_valid (byte_valid),
		.byte_out   (byte_out),
		.dsr_out    (dsr_out),
		.cts_out    (cts_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs somewhere.
	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

	// Offer one request after a random gap, hold it until accepted, then record it.
	// Valid stays high after acceptance so back-to-back requests need no extra edge.
	// The stall is looked at mid-cycle, where it is settled for the coming edge.
	task automatic send_request(input logic o, input logic [11:0] x, input logic [11:0] y,
			input logic [2:0] b, input logic d, input logic r);
		int gap;
		if ($urandom_range(29) == 0)
			send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		pos_x    <= x;
		pos_y    <= y;
		buttons  <= b;
		dtr      <= d;
		rts      <= r;
		forever begin
			@(negedge clk);
			if (!in_stall)
				break;
		end
		@(posedge clk);
		board.note_request(o, x, y, b, d, r);
	endtask

	// Tick until the ring is empty; positions are ignored meanwhile, so send noise.
	task automatic flush_ring();
		while (board.queued_bytes() != 0)
			send_request(OP_TICK, 12'($urandom), 12'($urandom), 3'($urandom),
				1'($urandom), 1'($urandom));
	endtask

	// Drop valid, then wait for every reply and let the block settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_protocol(input logic v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		board.proto = v;
	endtask

	// Tick with motion: mostly small steps, some large ones that split into
	// many packets, some jumps anywhere, some with no motion at all.
	task automatic random_tick();
		int k;
		int dx;
		int dy;
		k  = $urandom_range(99);
		dx = 0;
		dy = 0;
		if (k < 60) begin
			dx = int'($urandom_range(40)) - 20;
			dy = int'($urandom_range(40)) - 20;
		end else if (k < 80) begin
			dx = int'($urandom_range(600)) - 300;
			dy = int'($urandom_range(600)) - 300;
		end else if (k < 92) begin
			cur_x = 12'($urandom);
			cur_y = 12'($urandom);
		end
		cur_x = cur_x + 12'(dx);
		cur_y = cur_y + 12'(dy);
		if ($urandom_range(3) == 0)
			cur_btn = 3'($urandom_range(7));
		send_request(OP_TICK, cur_x, cur_y, cur_btn, 1'($urandom), 1'($urandom));
	endtask

	// Mostly ticks; line updates now and then, and quickly while scanning is off
	// so that little time is spent on ignored ticks.
	task automatic random_request();
		bit lines;
		lines = board.scanning ? ($urandom_range(99) < 6) : ($urandom_range(2) == 0);
		if (lines)
			send_request(OP_LINES, 12'($urandom), 12'($urandom), 3'($urandom),
				1'($urandom), 1'($urandom_range(9) < 7));
		else
			random_tick();
	endtask

	// Sink side: stall a random while, then take one reply and check it.
	// Valid and the fields are looked at mid-cycle, before the edge that takes them.
	initial begin : reply_side
		int     hold;
		reply_t got;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(29) == 0)
				recv_burst = !recv_burst;
			hold = recv_burst ? 0 : $urandom_range(9);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			forever begin
				@(negedge clk);
				if (out_valid)
					break;
			end
			got.byte_valid = byte_valid;
			got.byte_out   = byte_out;
			got.dsr        = dsr_out;
			got.cts        = cts_out;
			@(posedge clk);
			board.check_reply(got);
		end
	end

	initial begin : stimulus
		board      = new();
		send_burst = 1'b0;
		recv_burst = 1'b0;
		cur_x      = 12'd0;
		cur_y      = 12'd0;
		cur_btn    = 3'd0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		op        <= OP_TICK;
		pos_x     <= 12'd0;
		pos_y     <= 12'd0;
		buttons   <= 3'd0;
		dtr       <= 1'b0;
		rts       <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_protocol(PROTO_THREE);

		// Tick before scanning ever started: ignored.
		send_request(OP_TICK, 12'hFFF, 12'hFFF, 3'b111, 1'b1, 1'b1);
		// CTS already high after reset: no rising edge, lines only.
		send_request(OP_LINES, 12'h000, 12'h000, 3'b000, 1'b1, 1'b1);
		// Drop DSR alone.
		send_request(OP_LINES, 12'hFFF, 12'hFFF, 3'b111, 1'b0, 1'b1);
		// Falling CTS, then a tick that must stay silent.
		send_request(OP_LINES, 12'h000, 12'h000, 3'b000, 1'b0, 1'b0);
		send_request(OP_TICK, 12'hABC, 12'h543, 3'b101, 1'b0, 1'b0);
		// Rising CTS: identification bytes queued, scanning on.
		send_request(OP_LINES, 12'h000, 12'h000, 3'b000, 1'b1, 1'b1);
		// Ring holds the ID bytes, so these samples are ignored.
		send_request(OP_TICK, 12'h7FF, 12'h800, 3'b100, 1'b0, 1'b0);
		send_request(OP_TICK, 12'h7FF, 12'h800, 3'b100, 1'b0, 1'b0);
		// Largest positive X and negative Y step with a middle change: long split.
		send_request(OP_TICK, 12'h7FF, 12'h800, 3'b100, 1'b0, 1'b0);
		flush_ring();
		// No motion and no button change: nothing queued, no byte.
		send_request(OP_TICK, 12'h7FF, 12'h800, 3'b100, 1'b1, 1'b0);
		// Exactly one packet at the clamp limits.
		send_request(OP_TICK, 12'h87E, 12'h780, 3'b011, 1'b0, 1'b1);
		flush_ring();
		// Just past the limits: two packets; fall with bytes still queued.
		send_request(OP_TICK, 12'h7FD, 12'h800, 3'b000, 1'b0, 1'b0);
		send_request(OP_TICK, 12'h000, 12'h000, 3'b000, 1'b0, 1'b0);
		send_request(OP_LINES, 12'h000, 12'h000, 3'b000, 1'b1, 1'b0);
		send_request(OP_TICK, 12'h123, 12'h456, 3'b010, 1'b0, 1'b0);
		wait_idle();

		write_protocol(PROTO_FIVE);
		// Rise without ID bytes, then the opposite extreme X step.
		send_request(OP_LINES, 12'h000, 12'h000, 3'b000, 1'b1, 1'b1);
		send_request(OP_TICK, 12'hFFD, 12'h7FC, 3'b101, 1'b0, 1'b0);
		flush_ring();
		send_request(OP_TICK, 12'hFFE, 12'h7FB, 3'b010, 1'b1, 1'b1);
		flush_ring();
		cur_x   = 12'hFFE;
		cur_y   = 12'h7FB;
		cur_btn = 3'b010;
		wait_idle();

		// Random phases, alternating the protocol.
		for (int phase = 0; phase < 4; phase++) begin
			write_protocol((phase % 2 == 0) ? PROTO_THREE : PROTO_FIVE);
			// Restart scanning so the phase begins from a known line state.
			send_request(OP_LINES, 12'($urandom), 12'($urandom), 3'($urandom), 1'b1, 1'b0);
			send_request(OP_LINES, 12'($urandom), 12'($urandom), 3'($urandom), 1'b1, 1'b1);
			for (int n = 0; n < 120; n++)
				random_request();
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
